### sv/cfrs_pkg.sv
// cfrs_pkg: shared widths, rule word layout and stage word for the can frame rule switch
// no dependencies; compiled first
`default_nettype none

package cfrs_pkg;

    localparam int unsigned FRAME_ID_W     = 11;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BYTE_CNT       = 8;
    localparam int unsigned BYTE_SEL_W     = 3;
    localparam int unsigned PIN_CNT        = 64;
    localparam int unsigned PIN_SEL_W      = 6;
    localparam int unsigned RULE_ID_W      = 16;
    localparam int unsigned REG_COUNT      = 8;
    localparam int unsigned REG_IDX_W      = 3;
    localparam int unsigned RULE_W         = 46;
    localparam int unsigned RULE_COUNT_DEF = 8;

    typedef enum logic [2:0] {
        CMP_EQ  = 3'd0,
        CMP_NE  = 3'd1,
        CMP_GT  = 3'd2,
        CMP_LT  = 3'd3,
        CMP_AND = 3'd4,
        CMP_XOR = 3'd5
    } t_cmp;

    typedef enum logic [1:0] {
        ACT_ON     = 2'd0,
        ACT_OFF    = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_act;

    // msb first, matches the configuration word bit layout
    typedef struct packed {
        t_act                  action;
        logic [PIN_SEL_W-1:0]  pin;
        t_cmp                  cmp;
        logic [BYTE_W-1:0]     value;
        logic [BYTE_W-1:0]     mask;
        logic [BYTE_SEL_W-1:0] bytepos;
        logic [RULE_ID_W-1:0]  id;
    } t_rule;

    // word handed from cell to cell
    typedef struct packed {
        logic                             valid;
        logic [FRAME_ID_W-1:0]            id;
        logic [BYTE_CNT-1:0][BYTE_W-1:0]  bytes;
        logic [PIN_CNT-1:0]               pins;
        logic [REG_COUNT-1:0]             fired;
    } t_stage;

endpackage

`default_nettype wire

### sv/cfrs_if.sv
// cfrs_in_if / cfrs_out_if: valid-ready channels for frames in and results out
// depends on cfrs_pkg
`default_nettype none

interface cfrs_in_if import cfrs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FRAME_ID_W-1:0] frame_id;
    logic [BYTE_W-1:0]     data_byte_0;
    logic [BYTE_W-1:0]     data_byte_1;
    logic [BYTE_W-1:0]     data_byte_2;
    logic [BYTE_W-1:0]     data_byte_3;
    logic [BYTE_W-1:0]     data_byte_4;
    logic [BYTE_W-1:0]     data_byte_5;
    logic [BYTE_W-1:0]     data_byte_6;
    logic [BYTE_W-1:0]     data_byte_7;

    modport source (
        output valid, frame_id, data_byte_0, data_byte_1, data_byte_2, data_byte_3,
               data_byte_4, data_byte_5, data_byte_6, data_byte_7,
        input  ready
    );
    modport sink (
        input  valid, frame_id, data_byte_0, data_byte_1, data_byte_2, data_byte_3,
               data_byte_4, data_byte_5, data_byte_6, data_byte_7,
        output ready
    );
endinterface

interface cfrs_out_if import cfrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIN_CNT-1:0]   pin_levels;
    logic [REG_COUNT-1:0] fired_rules;

    modport source (output valid, pin_levels, fired_rules, input ready);
    modport sink   (input valid, pin_levels, fired_rules, output ready);
endinterface

`default_nettype wire

### sv/cfrs_cell.sv
// cfrs_cell: one rule of the chain; holds its rule word, tests the passing frame
// and hands the updated pin vector and fired mask to the next cell; uses cfrs_pkg
`default_nettype none

module cfrs_cell import cfrs_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [RULE_W-1:0]    i_cfg_data,
    input  wire t_stage               i_stage,
    output t_stage                    o_stage
);

    t_rule             r_rule;
    t_stage            r_stage;
    t_stage            n_stage;
    logic [BYTE_W-1:0] w_sel;
    logic              w_hold;
    logic              w_id_match;
    logic              w_hit;

    assign w_sel      = i_stage.bytes[r_rule.bytepos] & r_rule.mask;
    assign w_id_match = (r_rule.id == {{(RULE_ID_W-FRAME_ID_W){1'b0}}, i_stage.id});

    always_comb begin
        case (r_rule.cmp)
            CMP_EQ:  w_hold = (w_sel == r_rule.value);
            CMP_NE:  w_hold = (w_sel != r_rule.value);
            CMP_GT:  w_hold = (w_sel > r_rule.value);
            CMP_LT:  w_hold = (w_sel < r_rule.value);
            CMP_AND: w_hold = |(w_sel & r_rule.value);
            CMP_XOR: w_hold = |(w_sel ^ r_rule.value);
            default: w_hold = 1'b0;
        endcase
    end

    assign w_hit = i_stage.valid && w_id_match && w_hold;

    always_comb begin
        n_stage = i_stage;
        if (w_hit) begin
            n_stage.fired[REG_IDX_W'(CELL_IDX)] = 1'b1;
            case (r_rule.action)
                ACT_ON:     n_stage.pins[r_rule.pin] = 1'b0;
                ACT_OFF:    n_stage.pins[r_rule.pin] = 1'b1;
                ACT_TOGGLE: n_stage.pins[r_rule.pin] = ~i_stage.pins[r_rule.pin];
                default:    n_stage.pins = i_stage.pins;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule        <= t_rule'('0);
            r_stage.valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_IDX_W'(CELL_IDX))) begin
                r_rule <= t_rule'(i_cfg_data);
            end
            if (i_adv) begin
                r_stage <= n_stage;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

### sv/can_frame_rule_output_switch_top.sv
// can frame rule output switch: top level
// usage notes
//   frames enter on i_frm (valid/ready); one result word per frame leaves on o_res
//   rules are written through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle,
//   index i selects rule i; writes to rules at or above RULE_COUNT have no effect
//   a frame walks a row of RULE_COUNT cells, one rule per cell per cycle, rule 0 first,
//   each cell passing the pin vector it left to the next one
//   a result passes through every cell register and then the output register to o_res
//   only one frame is in the row at a time; a new frame is taken in the cycle the
//   previous one leaves the last cell, with the last cell's pin vector bypassed to cell 0
//   the output register lets one finished result wait while the next frame is in the row
//   if o_res stalls and a second frame reaches the last cell, the row holds and i_frm
//   stays not ready until the waiting word is taken
//   reset clears all rules to zero, sets every pin level to one (inactive) and empties
//   the row and the output register
`default_nettype none

module can_frame_rule_output_switch_top import cfrs_pkg::*; #(
    parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cfrs_in_if.sink                   i_frm,
    cfrs_out_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [RULE_W-1:0]    i_cfg_data
);

    t_stage               w_stage [RULE_COUNT+1];
    t_stage               w_last;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_adv;
    logic                 w_in_ready;
    logic                 r_busy;
    logic                 r_out_valid;
    logic [PIN_CNT-1:0]   r_out_pins;
    logic [REG_COUNT-1:0] r_out_fired;
    logic [PIN_CNT-1:0]   r_pin_vector;

    assign w_last     = w_stage[RULE_COUNT];
    assign w_load     = w_last.valid && (!r_out_valid || o_res.ready);
    assign w_adv      = !w_last.valid || w_load;
    assign w_in_ready = !r_busy || w_load;
    assign w_accept   = i_frm.valid && w_in_ready;

    always_comb begin
        w_stage[0].valid = w_accept;
        w_stage[0].id    = i_frm.frame_id;
        w_stage[0].bytes = {i_frm.data_byte_7, i_frm.data_byte_6, i_frm.data_byte_5,
                            i_frm.data_byte_4, i_frm.data_byte_3, i_frm.data_byte_2,
                            i_frm.data_byte_1, i_frm.data_byte_0};
        // a busy row means the previous frame is leaving this cycle
        w_stage[0].pins  = r_busy ? w_last.pins : r_pin_vector;
        w_stage[0].fired = '0;
    end

    for (genvar g = 0; g < RULE_COUNT; g++) begin : g_cell
        cfrs_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_cfg_we   (i_cfg_we),
            .i_cfg_idx  (i_cfg_idx),
            .i_cfg_data (i_cfg_data),
            .i_stage    (w_stage[g]),
            .o_stage    (w_stage[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pin_vector <= '1;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_pin_vector <= w_last.pins;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pins  <= w_last.pins;
            r_out_fired <= w_last.fired;
        end
    end

    assign i_frm.ready       = w_in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.pin_levels  = r_out_pins;
    assign o_res.fired_rules = r_out_fired;

endmodule

`default_nettype wire

### sv/cfrs_chk.sv
// cfrs_chk: port-level checks for the can frame rule switch, bound to the top level
// depends on cfrs_pkg
`default_nettype none

module cfrs_chk import cfrs_pkg::*; #(
    parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [PIN_CNT-1:0]   i_pin_levels,
    input wire logic [REG_COUNT-1:0] i_fired_rules
);

    logic [PIN_CNT-1:0] r_last_pins;

    // pin levels of the last word taken, all inactive after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pins <= '1;
        end else if (i_out_valid && i_out_ready) begin
            r_last_pins <= i_pin_levels;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pin_levels) && $stable(i_fired_rules))
        else $error("result word changed while stalled");

    a_no_extra_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((REG_COUNT)'({{REG_COUNT{1'b0}}, i_fired_rules} >> RULE_COUNT) == '0))
        else $error("fired bit set for a rule beyond the rule count");

    a_pins_by_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ($countones(i_pin_levels ^ r_last_pins) <= $countones(i_fired_rules)))
        else $error("more pins changed than rules fired");

    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RULE_COUNT > 1) && i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second frame taken while one is in the row");

endmodule

bind can_frame_rule_output_switch_top cfrs_chk #(
    .RULE_COUNT (RULE_COUNT)
) u_cfrs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_frm.valid),
    .i_in_ready    (i_frm.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_pin_levels  (o_res.pin_levels),
    .i_fired_rules (o_res.fired_rules)
);

`default_nettype wire

### sim/cfrs_result_check.sv
// cfrs_result_check: watches the frame and result channels and the rule write port,
// predicts pin levels and fired rules per frame and compares every result word
// depends on cfrs_pkg and the cfrs_in_if / cfrs_out_if interfaces
`timescale 1ns / 100ps

module cfrs_result_check import cfrs_pkg::*; #(
    parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cfrs_in_if                        i_frm,
    cfrs_out_if                       i_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [RULE_W-1:0]    i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [PIN_CNT-1:0]   pins;
        logic [REG_COUNT-1:0] fired;
    } t_switch_word;

    t_rule              rule_tbl [REG_COUNT];
    logic [PIN_CNT-1:0] pin_state;
    t_switch_word       pin_words_q [$];

    function automatic bit cmp_holds(t_cmp code, logic [BYTE_W-1:0] lhs, logic [BYTE_W-1:0] rhs);
        case (code)
            CMP_EQ:  return lhs == rhs;
            CMP_NE:  return lhs != rhs;
            CMP_GT:  return lhs > rhs;
            CMP_LT:  return lhs < rhs;
            CMP_AND: return (lhs & rhs) != '0;
            CMP_XOR: return (lhs ^ rhs) != '0;
            default: return 1'b0;
        endcase
    endfunction

    // walks the rules in order; a later rule sees the pins left by an earlier one
    function automatic t_switch_word switch_frame(logic [FRAME_ID_W-1:0] fid,
                                                  logic [BYTE_CNT-1:0][BYTE_W-1:0] fb);
        t_switch_word      outcome;
        t_rule             r;
        logic [BYTE_W-1:0] sel;
        outcome.fired = '0;
        for (int k = 0; k < RULE_COUNT; k++) begin
            r   = rule_tbl[k];
            sel = fb[r.bytepos] & r.mask;
            // wide ids are compared against the zero-extended frame id
            if (r.id == {{(RULE_ID_W-FRAME_ID_W){1'b0}}, fid} && cmp_holds(r.cmp, sel, r.value)) begin
                outcome.fired[k] = 1'b1;
                case (r.action)
                    ACT_ON:     pin_state[r.pin] = 1'b0;
                    ACT_OFF:    pin_state[r.pin] = 1'b1;
                    ACT_TOGGLE: pin_state[r.pin] = ~pin_state[r.pin];
                    default: ;
                endcase
            end
        end
        outcome.pins = pin_state;
        return outcome;
    endfunction

    always @(posedge i_clk) begin : watch
        t_switch_word                    want;
        logic [BYTE_CNT-1:0][BYTE_W-1:0] frame_bytes;
        if (!i_rst_n) begin
            for (int r = 0; r < REG_COUNT; r++) begin
                rule_tbl[r] = '0;
            end
            pin_state = '1;
            pin_words_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                rule_tbl[i_cfg_idx] = t_rule'(i_cfg_data);
            end
            if (i_res.valid && i_res.ready) begin
                if (pin_words_q.size() == 0) begin
                    $error("result word with no frame outstanding: pin_levels %h fired_rules %h",
                           i_res.pin_levels, i_res.fired_rules);
                    o_fail_count++;
                end else begin
                    want = pin_words_q.pop_front();
                    if (i_res.pin_levels !== want.pins) begin
                        $error("pin_levels: expected %h, got %h", want.pins, i_res.pin_levels);
                        o_fail_count++;
                    end
                    if (i_res.fired_rules !== want.fired) begin
                        $error("fired_rules: expected %h, got %h", want.fired, i_res.fired_rules);
                        o_fail_count++;
                    end
                end
            end
            if (i_frm.valid && i_frm.ready) begin
                frame_bytes = {i_frm.data_byte_7, i_frm.data_byte_6, i_frm.data_byte_5,
                               i_frm.data_byte_4, i_frm.data_byte_3, i_frm.data_byte_2,
                               i_frm.data_byte_1, i_frm.data_byte_0};
                pin_words_q.push_back(switch_frame(i_frm.frame_id, frame_bytes));
            end
            o_pending = pin_words_q.size();
        end
    end

endmodule

### sim/can_frame_rule_output_switch_top_tb.sv
// can_frame_rule_output_switch_top_tb: drives frames, rule writes and result back-pressure,
// directed rule sets first, then random phases; the result checker does the comparing
// depends on cfrs_pkg, the channel interfaces, cfrs_result_check and the block's top
`timescale 1ns / 100ps

module can_frame_rule_output_switch_top_tb import cfrs_pkg::*; ();

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = RULE_COUNT_DEF + 4;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_FRAMES = 215;
    // compare codes with no operation behind them
    localparam logic [2:0]  CMP_UNUSED_LO = 3'd6;
    localparam logic [2:0]  CMP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [FRAME_ID_W-1:0]           id;
        logic [BYTE_CNT-1:0][BYTE_W-1:0] bytes;
    } t_frame;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [RULE_W-1:0]    cfg_data;

    int fail_count;
    int pending;

    bit hold_off_req = 1'b0;
    bit stalls_on    = 1'b0;
    bit gaps_on      = 1'b0;

    t_rule                 cur_rules [REG_COUNT];
    logic [FRAME_ID_W-1:0] id_pool [4];

    cfrs_in_if  frm_if ();
    cfrs_out_if res_if ();

    can_frame_rule_output_switch_top #(
        .RULE_COUNT (RULE_COUNT_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frm      (frm_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cfrs_result_check #(
        .RULE_COUNT (RULE_COUNT_DEF)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frm        (frm_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short, now and then long
    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40)) : int'($urandom_range(1, 3));
    endfunction

    function automatic t_rule mk_rule(logic [RULE_ID_W-1:0] rid, logic [BYTE_SEL_W-1:0] pos,
                                      logic [BYTE_W-1:0] msk, logic [BYTE_W-1:0] ref_val,
                                      t_cmp code, logic [PIN_SEL_W-1:0] pin_no, t_act act);
        return '{action: act, pin: pin_no, cmp: code, value: ref_val, mask: msk,
                 bytepos: pos, id: rid};
    endfunction

    function automatic t_frame mk_frame(logic [FRAME_ID_W-1:0] fid, logic [63:0] payload);
        return '{id: fid, bytes: payload};
    endfunction

    function automatic t_rule rand_rule();
        t_rule r;
        r = t_rule'(RULE_W'({$urandom, $urandom}));
        case ($urandom_range(0, 9))
            0: ; // keep the full 16-bit id, mostly out of frame range
            1: r.id = '0;
            default: r.id = {{(RULE_ID_W-FRAME_ID_W){1'b0}}, id_pool[$urandom_range(0, 3)]};
        endcase
        if ($urandom_range(0, 1) == 0) begin
            r.mask = 8'hFF;
        end
        if ($urandom_range(0, 3) == 0) begin
            r.value = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        end
        // crowd some rules onto a few pins so they interact
        if ($urandom_range(0, 1) == 0) begin
            r.pin = PIN_SEL_W'($urandom_range(0, 3));
        end
        return r;
    endfunction

    function automatic t_frame rand_frame();
        t_frame f;
        t_rule  r;
        int     sel;
        f.id = FRAME_ID_W'($urandom);
        for (int i = 0; i < BYTE_CNT; i++) begin
            f.bytes[i] = BYTE_W'($urandom);
        end
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
            // aim at a configured rule, with the tested byte near its reference
            r    = cur_rules[$urandom_range(0, REG_COUNT - 1)];
            f.id = r.id[FRAME_ID_W-1:0];
            case ($urandom_range(0, 4))
                0: f.bytes[r.bytepos] = r.value;
                1: f.bytes[r.bytepos] = r.value + 8'd1;
                2: f.bytes[r.bytepos] = r.value - 8'd1;
                3: f.bytes[r.bytepos] = r.value | (BYTE_W'($urandom) & ~r.mask);
                default: ;
            endcase
        end else if (sel == 8) begin
            f.bytes = $urandom_range(0, 1) ? '0 : '1;
        end
        return f;
    endfunction

    task automatic send_frame(input t_frame f);
        int gap;
        gap = (gaps_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            frm_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frm_if.valid       <= 1'b1;
        frm_if.frame_id    <= f.id;
        frm_if.data_byte_0 <= f.bytes[0];
        frm_if.data_byte_1 <= f.bytes[1];
        frm_if.data_byte_2 <= f.bytes[2];
        frm_if.data_byte_3 <= f.bytes[3];
        frm_if.data_byte_4 <= f.bytes[4];
        frm_if.data_byte_5 <= f.bytes[5];
        frm_if.data_byte_6 <= f.bytes[6];
        frm_if.data_byte_7 <= f.bytes[7];
        do @(posedge i_clk); while (!frm_if.ready);
    endtask

    task automatic end_burst();
        frm_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_rules();
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_IDX_W'(i);
            cfg_data <= cur_rules[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // result side back-pressure
    initial begin : res_ready_drv
        forever begin
            if (hold_off_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        frm_if.valid       = 1'b0;
        frm_if.frame_id    = '0;
        frm_if.data_byte_0 = '0;
        frm_if.data_byte_1 = '0;
        frm_if.data_byte_2 = '0;
        frm_if.data_byte_3 = '0;
        frm_if.data_byte_4 = '0;
        frm_if.data_byte_5 = '0;
        frm_if.data_byte_6 = '0;
        frm_if.data_byte_7 = '0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rules: id 0, byte 0 masked to zero equals zero, so all eight clear pin 0
        send_frame(mk_frame(11'h000, 64'h0));
        send_frame(mk_frame(11'h7FF, '1));
        end_burst();

        // every compare code, same-pin ordering, wide ids
        cur_rules[0] = mk_rule(16'h0123, 3'd0, 8'hFF, 8'h10, CMP_EQ,  6'd0,  ACT_ON);
        cur_rules[1] = mk_rule(16'h0123, 3'd1, 8'hFF, 8'h10, CMP_NE,  6'd63, ACT_ON);
        cur_rules[2] = mk_rule(16'h0123, 3'd2, 8'hF0, 8'h80, CMP_GT,  6'd1,  ACT_TOGGLE);
        cur_rules[3] = mk_rule(16'h0123, 3'd3, 8'hFF, 8'h01, CMP_LT,  6'd1,  ACT_TOGGLE);
        cur_rules[4] = mk_rule(16'h07FF, 3'd4, 8'h0F, 8'h05, CMP_AND, 6'd2,  ACT_NONE);
        cur_rules[5] = mk_rule(16'h07FF, 3'd7, 8'hFF, 8'hFF, CMP_XOR, 6'd63, ACT_OFF);
        cur_rules[6] = mk_rule(16'h0800, 3'd5, 8'h00, 8'h00, CMP_EQ,  6'd3,  ACT_ON);
        cur_rules[7] = mk_rule(16'h0000, 3'd6, 8'h00, 8'h00, t_cmp'(CMP_UNUSED_LO), 6'd4, ACT_ON);
        load_rules();
        send_frame(mk_frame(11'h123, 64'h0000_0000_0090_1010));
        send_frame(mk_frame(11'h123, 64'h0000_0000_0180_0011));
        send_frame(mk_frame(11'h123, '1));
        send_frame(mk_frame(11'h123, 64'h0));
        send_frame(mk_frame(11'h7FF, 64'hFF00_0000_0000_0000));
        send_frame(mk_frame(11'h7FF, 64'h0000_0001_0000_0000));
        send_frame(mk_frame(11'h000, 64'h0));
        send_frame(mk_frame(11'h000, '1));
        send_frame(mk_frame(11'h124, 64'h0123_4567_89AB_CDEF));
        send_frame(mk_frame(11'h123, 64'h0000_0000_0090_1010));
        end_burst();

        // all-ones id must not alias 0x7FF; unused compare code; actions on one pin
        cur_rules[0] = mk_rule(16'hFFFF, 3'd0, 8'h00, 8'h00, CMP_EQ, 6'd5, ACT_ON);
        cur_rules[1] = mk_rule(16'h07FF, 3'd0, 8'hFF, 8'h00, t_cmp'(CMP_UNUSED_HI), 6'd6, ACT_ON);
        cur_rules[2] = mk_rule(16'h07FF, 3'd7, 8'h80, 8'h7F, CMP_GT, 6'd6,  ACT_TOGGLE);
        cur_rules[3] = mk_rule(16'h07FF, 3'd0, 8'hFF, 8'h00, CMP_NE, 6'd63, ACT_ON);
        cur_rules[4] = mk_rule(16'h07FF, 3'd1, 8'h00, 8'h00, CMP_EQ, 6'd62, ACT_ON);
        cur_rules[5] = mk_rule(16'h07FF, 3'd2, 8'h00, 8'h00, CMP_EQ, 6'd62, ACT_TOGGLE);
        cur_rules[6] = mk_rule(16'h07FF, 3'd3, 8'h00, 8'h00, CMP_EQ, 6'd62, ACT_OFF);
        cur_rules[7] = mk_rule(16'h07FF, 3'd4, 8'h00, 8'h00, CMP_EQ, 6'd61, ACT_NONE);
        load_rules();
        send_frame(mk_frame(11'h7FF, 64'h0));
        send_frame(mk_frame(11'h7FF, '1));
        send_frame(mk_frame(11'h7FF, 64'h8000_0000_0000_0001));
        send_frame(mk_frame(11'h000, 64'h0));
        end_burst();

        // every register bit set
        for (int i = 0; i < REG_COUNT; i++) begin
            cur_rules[i] = t_rule'({RULE_W{1'b1}});
        end
        load_rules();
        send_frame(mk_frame(11'h7FF, '1));
        send_frame(mk_frame(11'h000, 64'h0));
        end_burst();

        for (int p = 0; p < PHASES; p++) begin
            for (int i = 0; i < 4; i++) begin
                id_pool[i] = FRAME_ID_W'($urandom);
            end
            for (int i = 0; i < REG_COUNT; i++) begin
                cur_rules[i] = rand_rule();
            end
            load_rules();
            gaps_on   = (p != 0) && (p != 4);
            stalls_on = (p != 0) && (p != 3);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                // long result hold-off while frames keep coming
                if (p == 2 && n == 20) begin
                    hold_off_req = 1'b1;
                end
                send_frame(rand_frame());
            end
            end_burst();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("** can_frame_rule_output_switch_top: PASSED **");
        end else begin
            $display("** can_frame_rule_output_switch_top: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("** can_frame_rule_output_switch_top: FAILED **");
        $finish;
    end

endmodule
